// ----- src/cmfp_pkg.sv -----
`timescale 1ns / 1ps

package cmfp_pkg;

    localparam int INDEX_DEPTH = 4096;
    localparam int FRAME_DEPTH = 4096;
    localparam int INDEX_AW    = $clog2(INDEX_DEPTH);
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

    // Playback positions are 13 bits and wrap modulo 8192.
    localparam int POS_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_OUTER       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_INNER       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_SEGMENT_END = 2'd3;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_LOAD_INDEX = 2'd1;
    localparam logic [1:0] OP_LOAD_FRAME = 2'd2;

    // Command items of one frame, in emission order: three tone pairs
    // (command, data), the noise command, then four volume commands.
    localparam int NUM_ITEMS = 11;
    localparam int ITEM_W    = 4;
    localparam logic [ITEM_W-1:0] ITEM_NOISE = 4'd6;
    localparam logic [ITEM_W-1:0] ITEM_VOL0  = 4'd7;

    localparam logic [3:0] LED_LEVEL_MAX = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELEM_RD,
        S_ELEM,
        S_ENTRY_RD,
        S_ENTRY,
        S_HDR_RD,
        S_HDR,
        S_FETCH,
        S_NIB,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              found;
        logic [ITEM_W-1:0] idx;
    } t_pick;

    function automatic logic [NUM_ITEMS-1:0] item_mask(input logic [7:0] hdr);
        return {hdr[7:3], hdr[2], hdr[2], hdr[1], hdr[1], hdr[0], hdr[0]};
    endfunction

    // Items strictly after the given one.
    function automatic logic [NUM_ITEMS-1:0] above_mask(input logic [ITEM_W-1:0] item);
        return ~((NUM_ITEMS'(2) << item) - NUM_ITEMS'(1));
    endfunction

    function automatic t_pick first_item(input logic [NUM_ITEMS-1:0] m);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = NUM_ITEMS - 1; i >= 0; i--) begin
            if (m[i]) begin
                p.found = 1'b1;
                p.idx   = ITEM_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic item_is_data(input logic [ITEM_W-1:0] item);
        return (item < ITEM_NOISE) && item[0];
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [ITEM_W-1:0] item,
                                            input logic [3:0] nib,
                                            input logic [3:0] lo);
        logic [ITEM_W-1:0] rel;
        logic [7:0]        b;
        rel = item - ITEM_VOL0;
        if (item < ITEM_NOISE) begin
            if (item[0]) begin
                b = {nib, lo};
            end else begin
                b = {1'b1, item[2:1], 1'b0, nib};
            end
        end else if (item == ITEM_NOISE) begin
            b = {1'b1, 2'b11, 1'b0, nib};
        end else begin
            b = {1'b1, rel[1:0], 1'b1, nib};
        end
        return b;
    endfunction

endpackage

// ----- src/compressed_music_frame_player.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                      Payload
// input     i_start, o_busy                i_opcode, i_address, i_load_value
// result    o_strobe (one cycle)           o_chip_byte, o_led_bits, o_last
// config    i_cfg_valid, o_cfg_ready       i_cfg_index, i_cfg_data
//
// Loads and ignored opcodes leave o_busy low; a waiting tick passes through S_FIN only.
// A playing tick steps through S_ELEM_RD and S_ELEM if a new index element is read, then
// S_ENTRY_RD, S_ENTRY, S_HDR_RD, S_HDR, an S_NIB per nibble, an S_FETCH per byte fetched and
// S_FIN; the single frame read port and one-nibble-a-cycle unpacker pace a 14-nibble frame.
// Reset is synchronous and active low; the memories are not cleared.
// Results are presented for one cycle each; the receiver cannot stall them.

module compressed_music_frame_player (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [1:0]                         i_opcode,
    input  logic [11:0]                        i_address,
    input  logic [15:0]                        i_load_value,
    output logic                               o_strobe,
    output logic [7:0]                         o_chip_byte,
    output logic [3:0]                         o_led_bits,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cmfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cmfp_pkg::CFG_W-1:0]         i_cfg_data
);

    cmfp_pkg::t_state r_state, n_state;

    logic [cmfp_pkg::POS_W-1:0]    r_outer, n_outer;
    logic [cmfp_pkg::POS_W-1:0]    r_inner, n_inner;
    logic [cmfp_pkg::POS_W-1:0]    r_seg, n_seg;
    logic [3:0]                    r_wait, n_wait;
    logic [3:0]                    r_led, n_led;
    logic [cmfp_pkg::FRAME_AW-1:0] r_fpos, n_fpos;
    logic                          r_hi, n_hi;
    logic [7:0]                    r_hdr, n_hdr;
    logic [cmfp_pkg::ITEM_W-1:0]   r_item, n_item;
    logic                          r_part, n_part;
    logic [3:0]                    r_lo, n_lo;
    logic                          r_strobe, n_strobe;
    logic [7:0]                    r_byte, n_byte;
    logic                          r_last, n_last;

    logic [11:0] r_end;
    logic [11:0] r_loop_outer;
    logic [11:0] r_loop_inner;
    logic [12:0] r_loop_seg;

    logic        w_accept;
    logic        w_cfg_we;
    logic [15:0] w_idx_rdata;
    logic [7:0]  w_frm_rdata;
    logic        w_idx_re;
    logic        w_frm_re;
    logic [cmfp_pkg::INDEX_AW-1:0] w_idx_raddr;
    logic [3:0]  w_nib;
    logic        w_data_first;
    logic [cmfp_pkg::ITEM_W-1:0] w_vol_rel;
    cmfp_pkg::t_pick w_first;
    cmfp_pkg::t_pick w_next;

    assign w_accept    = i_start && (r_state == cmfp_pkg::S_IDLE);
    assign o_busy      = (r_state != cmfp_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    assign w_idx_re    = (r_state == cmfp_pkg::S_ELEM_RD) || (r_state == cmfp_pkg::S_ENTRY_RD);
    assign w_idx_raddr = (r_state == cmfp_pkg::S_ELEM_RD) ? r_outer[cmfp_pkg::INDEX_AW-1:0]
                                                          : r_inner[cmfp_pkg::INDEX_AW-1:0];
    assign w_frm_re    = (r_state == cmfp_pkg::S_HDR_RD) || (r_state == cmfp_pkg::S_FETCH);

    cmfp_ram #(
        .DEPTH (cmfp_pkg::INDEX_DEPTH),
        .WIDTH (16)
    ) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_opcode == cmfp_pkg::OP_LOAD_INDEX)),
        .i_waddr (i_address[cmfp_pkg::INDEX_AW-1:0]),
        .i_wdata (i_load_value),
        .i_re    (w_idx_re),
        .i_raddr (w_idx_raddr),
        .o_rdata (w_idx_rdata)
    );

    cmfp_ram #(
        .DEPTH (cmfp_pkg::FRAME_DEPTH),
        .WIDTH (8)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_opcode == cmfp_pkg::OP_LOAD_FRAME)),
        .i_waddr (i_address[cmfp_pkg::FRAME_AW-1:0]),
        .i_wdata (i_load_value[7:0]),
        .i_re    (w_frm_re),
        .i_raddr (r_fpos),
        .o_rdata (w_frm_rdata)
    );

    // Nibbles are taken low half first; the byte stays in the read register
    // until both halves are used.
    assign w_nib        = r_hi ? w_frm_rdata[7:4] : w_frm_rdata[3:0];
    assign w_data_first = cmfp_pkg::item_is_data(r_item) && !r_part;
    assign w_first      = cmfp_pkg::first_item(cmfp_pkg::item_mask(w_frm_rdata));
    assign w_next       = cmfp_pkg::first_item(cmfp_pkg::item_mask(r_hdr)
                                               & cmfp_pkg::above_mask(r_item));
    assign w_vol_rel    = r_item - cmfp_pkg::ITEM_VOL0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmfp_pkg::S_IDLE: begin
                if (w_accept && (i_opcode == cmfp_pkg::OP_TICK)) begin
                    if (r_wait != 4'd0) begin
                        n_state = cmfp_pkg::S_FIN;
                    end else if (r_inner == r_seg) begin
                        n_state = cmfp_pkg::S_ELEM_RD;
                    end else begin
                        n_state = cmfp_pkg::S_ENTRY_RD;
                    end
                end
            end
            cmfp_pkg::S_ELEM_RD:  n_state = cmfp_pkg::S_ELEM;
            cmfp_pkg::S_ELEM:     n_state = cmfp_pkg::S_ENTRY_RD;
            cmfp_pkg::S_ENTRY_RD: n_state = cmfp_pkg::S_ENTRY;
            cmfp_pkg::S_ENTRY:    n_state = cmfp_pkg::S_HDR_RD;
            cmfp_pkg::S_HDR_RD:   n_state = cmfp_pkg::S_HDR;
            cmfp_pkg::S_HDR: begin
                n_state = w_first.found ? cmfp_pkg::S_FETCH : cmfp_pkg::S_FIN;
            end
            cmfp_pkg::S_FETCH:    n_state = cmfp_pkg::S_NIB;
            cmfp_pkg::S_NIB: begin
                if (!w_data_first && !w_next.found) begin
                    n_state = cmfp_pkg::S_FIN;
                end else if (r_hi) begin
                    n_state = cmfp_pkg::S_FETCH;
                end else begin
                    n_state = cmfp_pkg::S_NIB;
                end
            end
            cmfp_pkg::S_FIN:      n_state = cmfp_pkg::S_IDLE;
            default:              n_state = cmfp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_outer  = r_outer;
        n_inner  = r_inner;
        n_seg    = r_seg;
        n_wait   = r_wait;
        n_led    = r_led;
        n_fpos   = r_fpos;
        n_hi     = r_hi;
        n_hdr    = r_hdr;
        n_item   = r_item;
        n_part   = r_part;
        n_lo     = r_lo;
        n_strobe = 1'b0;
        n_byte   = r_byte;
        n_last   = r_last;
        case (r_state)
            cmfp_pkg::S_ELEM: begin
                n_outer = r_outer + 13'd1;
                if (w_idx_rdata[15]) begin
                    n_inner = {1'b0, w_idx_rdata[11:0]};
                    n_seg   = {1'b0, w_idx_rdata[11:0]} + {10'd0, w_idx_rdata[14:12]}
                              + 13'd2;
                end else begin
                    n_inner = r_outer;
                    n_seg   = r_outer + 13'd1;
                end
            end
            cmfp_pkg::S_ENTRY: begin
                n_inner = r_inner + 13'd1;
                n_wait  = {1'b0, w_idx_rdata[14:12]} + 4'd1;
                n_fpos  = w_idx_rdata[cmfp_pkg::FRAME_AW-1:0];
            end
            cmfp_pkg::S_HDR: begin
                n_hdr  = w_frm_rdata;
                n_fpos = r_fpos + {{(cmfp_pkg::FRAME_AW-1){1'b0}}, 1'b1};
                n_hi   = 1'b0;
                n_part = 1'b0;
                n_item = w_first.idx;
            end
            cmfp_pkg::S_NIB: begin
                n_hi = !r_hi;
                if (r_hi) begin
                    n_fpos = r_fpos + {{(cmfp_pkg::FRAME_AW-1){1'b0}}, 1'b1};
                end
                if (w_data_first) begin
                    n_lo   = w_nib;
                    n_part = 1'b1;
                end else begin
                    n_part   = 1'b0;
                    n_strobe = 1'b1;
                    n_byte   = cmfp_pkg::cmd_byte(r_item, w_nib, r_lo);
                    n_last   = !w_next.found;
                    n_item   = w_next.idx;
                    if (r_item >= cmfp_pkg::ITEM_VOL0) begin
                        n_led[w_vol_rel[1:0]] = (w_nib <= cmfp_pkg::LED_LEVEL_MAX);
                    end
                end
            end
            cmfp_pkg::S_FIN: begin
                if (r_outer == {1'b0, r_end}) begin
                    n_outer = {1'b0, r_loop_outer};
                    n_inner = {1'b0, r_loop_inner};
                    n_seg   = r_loop_seg;
                end
                if (r_wait != 4'd0) begin
                    n_wait = r_wait - 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cmfp_pkg::S_IDLE;
            r_outer  <= '0;
            r_inner  <= '0;
            r_seg    <= '0;
            r_wait   <= '0;
            r_led    <= '0;
            r_part   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_outer  <= n_outer;
            r_inner  <= n_inner;
            r_seg    <= n_seg;
            r_wait   <= n_wait;
            r_led    <= n_led;
            r_part   <= n_part;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fpos <= n_fpos;
        r_hi   <= n_hi;
        r_hdr  <= n_hdr;
        r_item <= n_item;
        r_lo   <= n_lo;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end        <= '0;
            r_loop_outer <= '0;
            r_loop_inner <= '0;
            r_loop_seg   <= '0;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                cmfp_pkg::CFG_END_INDEX:        r_end        <= i_cfg_data[11:0];
                cmfp_pkg::CFG_LOOP_OUTER:       r_loop_outer <= i_cfg_data[11:0];
                cmfp_pkg::CFG_LOOP_INNER:       r_loop_inner <= i_cfg_data[11:0];
                cmfp_pkg::CFG_LOOP_SEGMENT_END: r_loop_seg   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_chip_byte = r_byte;
    assign o_led_bits  = r_led;
    assign o_last      = r_last;

`ifndef SYNTH
    a_strobe_from_unpack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == cmfp_pkg::S_NIB))
        else $error("result strobe outside the unpack step");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> (!o_strobe && (r_state == cmfp_pkg::S_IDLE)))
        else $error("transaction after the final command byte of a tick");

    a_busy_ends_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(r_state == cmfp_pkg::S_FIN))
        else $error("tick ended without the loop check");

    a_part_on_data_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part |-> ((r_state == cmfp_pkg::S_NIB || r_state == cmfp_pkg::S_FETCH)
                    && cmfp_pkg::item_is_data(r_item)))
        else $error("half-built data byte on a non-data item");
`endif

endmodule

// ----- src/cmfp_ram.sv -----
`timescale 1ns / 1ps

module cmfp_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE      = 48;      // more than the longest tick
    localparam int         CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [cmfp_pkg::POS_W-1:0] outer;
        logic [cmfp_pkg::POS_W-1:0] inner;
        logic [cmfp_pkg::POS_W-1:0] seg_end;
        logic [cmfp_pkg::POS_W-1:0] frame_pos;
        logic                       high_nib;
        logic [3:0]                 wait_cnt;
        logic [3:0]                 leds;
    } t_player;

    typedef struct packed {
        logic [7:0] chip_byte;
        logic [3:0] leds;
        logic       last;
    } t_chip_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_opcode = cmfp_pkg::OP_TICK;
    logic [11:0] i_address = '0;
    logic [15:0] i_load_value = '0;
    logic        i_cfg_valid = 1'b0;
    logic [cmfp_pkg::CFG_IDX_W-1:0] i_cfg_index = cmfp_pkg::CFG_END_INDEX;
    logic [cmfp_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_chip_byte;
    logic [3:0]  o_led_bits;
    logic        o_last;
    logic        o_cfg_ready;

    compressed_music_frame_player i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_load_value (i_load_value),
        .o_strobe     (o_strobe),
        .o_chip_byte  (o_chip_byte),
        .o_led_bits   (o_led_bits),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the player: stores, which entries hold data, playback state and loop registers.
    logic [15:0]      index_mem [cmfp_pkg::INDEX_DEPTH];
    logic [7:0]       frame_mem [cmfp_pkg::FRAME_DEPTH];
    bit               index_loaded [cmfp_pkg::INDEX_DEPTH];
    bit               frame_loaded [cmfp_pkg::FRAME_DEPTH];
    t_player          play = '0;
    logic [11:0]      cfg_end = '0;
    logic [11:0]      cfg_outer = '0;
    logic [11:0]      cfg_inner = '0;
    logic [cmfp_pkg::POS_W-1:0] cfg_seg_end = '0;

    // Side outputs of one predicted tick.
    logic [7:0]  tick_bytes [cmfp_pkg::NUM_ITEMS];
    logic [3:0]  tick_leds [cmfp_pkg::NUM_ITEMS];
    int          tick_len;
    bit          loop_hit;
    bit          miss_hit;
    bit          miss_in_frame;
    logic [11:0] miss_addr;

    t_chip_cmd expected_cmds [$];
    bit        sender_idles = 1'b1;
    int        error_count = 0;
    int        cmds_checked = 0;
    int        ticks_sent = 0;
    int        loads_sent = 0;
    int        reload_count = 0;
    int        cycle_count = 0;

    function automatic logic [15:0] read_index(input logic [cmfp_pkg::POS_W-1:0] pos);
        if (!index_loaded[pos[11:0]]) begin
            if (!miss_hit) begin
                miss_in_frame = 1'b0;
                miss_addr = pos[11:0];
            end
            miss_hit = 1'b1;
            return 16'h0;
        end
        return index_mem[pos[11:0]];
    endfunction

    function automatic logic [7:0] read_frame(input logic [cmfp_pkg::POS_W-1:0] pos);
        if (!frame_loaded[pos[11:0]]) begin
            if (!miss_hit) begin
                miss_in_frame = 1'b1;
                miss_addr = pos[11:0];
            end
            miss_hit = 1'b1;
            return 8'h0;
        end
        return frame_mem[pos[11:0]];
    endfunction

    // Frame data is packed low nibble first.
    function automatic logic [3:0] take_nibble(inout t_player s);
        logic [7:0] b;
        b = read_frame(s.frame_pos);
        if (s.high_nib) begin
            s.high_nib = 1'b0;
            s.frame_pos = s.frame_pos + 13'd1;
            return b[7:4];
        end
        s.high_nib = 1'b1;
        return b[3:0];
    endfunction

    function automatic void emit_cmd(input logic [7:0] b, input logic [3:0] leds);
        tick_bytes[tick_len] = b;
        tick_leds[tick_len] = leds;
        tick_len++;
    endfunction

    // Advances the player by one tick. Returns 0 if the tick touched a store entry
    // that was never loaded; miss_addr then names the first such entry.
    function automatic bit play_tick(inout t_player s);
        logic [15:0] elem;
        logic [15:0] entry;
        logic [7:0]  hdr;
        logic [3:0]  nib;
        logic [3:0]  lo;
        logic [3:0]  hi;
        miss_hit = 1'b0;
        loop_hit = 1'b0;
        tick_len = 0;
        if (s.wait_cnt == 4'd0) begin
            if (s.inner == s.seg_end) begin
                elem = read_index(s.outer);
                s.outer = s.outer + 13'd1;
                if (elem[15]) begin
                    s.inner = {1'b0, elem[11:0]};
                    s.seg_end = s.inner + 13'(elem[14:12]) + 13'd2;
                end else begin
                    s.inner = s.outer - 13'd1;
                    s.seg_end = s.outer;
                end
            end
            entry = read_index(s.inner);
            s.inner = s.inner + 13'd1;
            s.wait_cnt = {1'b0, entry[14:12]} + 4'd1;
            s.frame_pos = {1'b0, entry[11:0]};
            hdr = read_frame(s.frame_pos);
            s.frame_pos = s.frame_pos + 13'd1;
            for (int t = 0; t < 3; t++) begin
                if (hdr[t]) begin
                    nib = take_nibble(s);
                    emit_cmd({1'b1, 2'(t), 1'b0, nib}, s.leds);
                    lo = take_nibble(s);
                    hi = take_nibble(s);
                    emit_cmd({hi, lo}, s.leds);
                end
            end
            if (hdr[3]) begin
                nib = take_nibble(s);
                emit_cmd({4'b1110, nib}, s.leds);
            end
            for (int t = 0; t < 4; t++) begin
                if (hdr[4 + t]) begin
                    nib = take_nibble(s);
                    s.leds[t] = (nib <= cmfp_pkg::LED_LEVEL_MAX);
                    emit_cmd({1'b1, 2'(t), 1'b1, nib}, s.leds);
                end
            end
            // A frame never ends in the middle of a byte.
            if (s.high_nib) begin
                s.high_nib = 1'b0;
                s.frame_pos = s.frame_pos + 13'd1;
            end
        end
        if (s.outer == {1'b0, cfg_end}) begin
            s.outer = {1'b0, cfg_outer};
            s.inner = {1'b0, cfg_inner};
            s.seg_end = cfg_seg_end;
            loop_hit = 1'b1;
        end
        if (s.wait_cnt != 4'd0)
            s.wait_cnt = s.wait_cnt - 4'd1;
        return !miss_hit;
    endfunction

    function automatic logic [15:0] pick_index_word();
        logic [15:0] w;
        w = 16'($urandom);
        w[15] = ($urandom_range(99) < 35);
        if ($urandom_range(99) < 50)
            w[14:12] = 3'd0;
        return w;
    endfunction

    function automatic logic [7:0] pick_frame_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'hFF;
        if (r < 15)
            return 8'h00;
        return 8'($urandom);
    endfunction

    // Leaves i_start high after the transaction; the caller either sends again or
    // lowers it in the same time step.
    task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                             input logic [15:0] value);
        int gap;
        if (sender_idles && $urandom_range(99) < 8) begin
            gap = $urandom_range(1, 12);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_opcode <= op;
        i_address <= addr;
        i_load_value <= value;
        do @(posedge i_clk); while (o_busy);
        case (op)
            cmfp_pkg::OP_LOAD_INDEX: begin
                index_mem[addr] = value;
                index_loaded[addr] = 1'b1;
                loads_sent++;
            end
            cmfp_pkg::OP_LOAD_FRAME: begin
                frame_mem[addr] = value[7:0];
                frame_loaded[addr] = 1'b1;
                loads_sent++;
            end
            cmfp_pkg::OP_TICK: begin
                void'(play_tick(play));
                ticks_sent++;
                if (loop_hit)
                    reload_count++;
                for (int i = 0; i < tick_len; i++)
                    expected_cmds.push_back({tick_bytes[i], tick_leds[i], i == tick_len - 1});
            end
            default: ;
        endcase
    endtask

    // Loads whatever the coming tick would read before it has been written, then ticks.
    task automatic send_tick();
        t_player trial;
        trial = play;
        while (!play_tick(trial)) begin
            if (miss_in_frame)
                send_item(cmfp_pkg::OP_LOAD_FRAME, miss_addr,
                          {8'($urandom), pick_frame_byte()});
            else
                send_item(cmfp_pkg::OP_LOAD_INDEX, miss_addr, pick_index_word());
            trial = play;
        end
        send_item(cmfp_pkg::OP_TICK, 12'($urandom), 16'($urandom));
    endtask

    task automatic wait_for_results();
        i_start <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [cmfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmfp_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cmfp_pkg::CFG_END_INDEX:        cfg_end = data[11:0];
            cmfp_pkg::CFG_LOOP_OUTER:       cfg_outer = data[11:0];
            cmfp_pkg::CFG_LOOP_INNER:       cfg_inner = data[11:0];
            cmfp_pkg::CFG_LOOP_SEGMENT_END: cfg_seg_end = data;
            default: ;
        endcase
    endtask

    // Only called once the player has gone quiet.
    task automatic write_loop_regs(input logic [11:0] end_v, input logic [11:0] outer_v,
                                   input logic [11:0] inner_v, input logic [12:0] seg_v);
        cfg_write(cmfp_pkg::CFG_END_INDEX, {1'b0, end_v});
        cfg_write(cmfp_pkg::CFG_LOOP_OUTER, {1'b0, outer_v});
        cfg_write(cmfp_pkg::CFG_LOOP_INNER, {1'b0, inner_v});
        cfg_write(cmfp_pkg::CFG_LOOP_SEGMENT_END, seg_v);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks over lazily loaded song data, with stray loads and ignored opcodes.
    // The loads that a tick pulls in count toward the total.
    task automatic random_playback(input int n_items);
        int start_total;
        int r;
        start_total = ticks_sent + loads_sent;
        while (ticks_sent + loads_sent - start_total < n_items) begin
            r = $urandom_range(99);
            if (r < 60) begin
                send_tick();
            end else if (r < 78) begin
                send_item(cmfp_pkg::OP_LOAD_INDEX, 12'($urandom), pick_index_word());
            end else if (r < 95) begin
                send_item(cmfp_pkg::OP_LOAD_FRAME, 12'($urandom),
                          {8'($urandom), pick_frame_byte()});
            end else begin
                send_item(OP_UNUSED, 12'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_directed_frames();
        // Full header: every tone, noise and volume command, with volumes 8, 9, 0 and 15.
        send_item(cmfp_pkg::OP_LOAD_INDEX, 12'h000, 16'h0010);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h010, 16'h00FF);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h011, 16'h00A5);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h012, 16'h003C);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h013, 16'h00F0);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h014, 16'h000F);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h015, 16'h007E);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h016, 16'h0098);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h017, 16'h00F0);
        send_tick();
        // Two-entry back reference at the top of the index store, wrapping to entry 0.
        // Its first frame sits at the last frame address and holds a lone noise nibble.
        send_item(cmfp_pkg::OP_LOAD_INDEX, 12'h001, 16'h8FFF);
        send_item(cmfp_pkg::OP_LOAD_INDEX, 12'hFFF, 16'h1FFF);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'hFFF, 16'h0008);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h000, 16'h005A);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'hFFE, 16'hFFFF);
        send_tick();
        send_tick();
        send_tick();
        // Empty header: nothing is sent to the chip.
        send_item(cmfp_pkg::OP_LOAD_INDEX, 12'h002, 16'h0020);
        send_item(cmfp_pkg::OP_LOAD_FRAME, 12'h020, 16'h0000);
        send_tick();
        send_item(OP_UNUSED, 12'hFFF, 16'hFFFF);
        wait_for_results();
    endtask

    task automatic test_loop_settings();
        write_loop_regs(12'(play.outer + 13'd2), 12'd0, 12'd0, 13'd0);
        random_playback(25);
        wait_for_results();
        write_loop_regs(12'(play.outer + 13'd3), 12'd4093, 12'd4095, 13'd4104);
        random_playback(25);
        wait_for_results();
        write_loop_regs(12'd4095, 12'd4095, 12'd10, 13'd12);
        random_playback(25);
        wait_for_results();
        write_loop_regs(12'd0, 12'd5, 12'd7, 13'd7);
        random_playback(25);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        sender_idles = 1'b0;
        random_playback(20);
        wait_for_results();
        random_playback(20);
        sender_idles = 1'b1;
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        t_chip_cmd want;
        if (i_rst_n && o_strobe) begin
            if (expected_cmds.size() == 0) begin
                $error("unexpected command byte %h", o_chip_byte);
                error_count++;
            end else begin
                want = expected_cmds.pop_front();
                cmds_checked++;
                if (o_chip_byte !== want.chip_byte) begin
                    $error("chip_byte: expected %h, got %h", want.chip_byte, o_chip_byte);
                    error_count++;
                end
                if (o_led_bits !== want.leds) begin
                    $error("led_bits: expected %h, got %h", want.leds, o_led_bits);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("compressed_music_frame_player verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_loop_settings();
        test_back_to_back();
        wait_for_results();
        $display("Played %0d ticks over %0d store loads; %0d command bytes checked.",
                 ticks_sent, loads_sent, cmds_checked);
        $display("Loop reloads seen: %0d, across four loop register settings.", reload_count);
        if (error_count == 0)
            $display("compressed_music_frame_player verification clean");
        else
            $display("compressed_music_frame_player verification failed");
        $finish;
    end

endmodule
